FILE: design/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg
// Shared constants and the command struct of the cosine similarity
// accumulator.
// ----------------------------------------------------------------------------
package csa_pkg;

    localparam int ELEMENT_BITS_DEF = 16;
    localparam int ACC_W            = 48;
    localparam int PROD_W           = 2 * ACC_W;
    localparam int ROOT_W           = ACC_W;
    localparam int FRAC_BITS        = 14;
    localparam int QUOT_W           = ACC_W + FRAC_BITS;
    localparam int VALUE_W          = 16;
    localparam int CNT_W            = 6;

    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(ACC_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUOT_W - 1);

    localparam logic [VALUE_W-1:0] ONE_Q14 = VALUE_W'(16384);

    typedef struct packed {
        logic load;
        logic mul_step;
        logic sqrt_step;
        logic div_step;
        logic finish;
    } csa_cmd_t;

endpackage

FILE: design/csa_datapath.sv
// ----------------------------------------------------------------------------
// csa_datapath
// Accumulators, a bit-serial norm multiplier, a digit-by-digit square root
// and a restoring divider.
// ----------------------------------------------------------------------------
module csa_datapath #(
    parameter int ELEMENT_BITS = csa_pkg::ELEMENT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic signed [ELEMENT_BITS-1:0]    left_element,
    input  logic signed [ELEMENT_BITS-1:0]    right_element,
    input  csa_pkg::csa_cmd_t                 cmd,
    output logic                              zero_norm,
    output logic signed [csa_pkg::VALUE_W-1:0] cosine_value,
    output logic                              result_valid
);
    import csa_pkg::*;

    localparam int PW = 2 * ELEMENT_BITS;

    logic signed [PW-1:0] dot_prod;
    logic signed [PW-1:0] left_sq;
    logic signed [PW-1:0] right_sq;
    logic [ACC_W:0]       dot_sum_wide;
    logic [ACC_W:0]       left_sum_wide;
    logic [ACC_W:0]       right_sum_wide;

    logic [ACC_W-1:0]  dot_sum_reg, dot_sum_next;
    logic [ACC_W-1:0]  left_norm_reg, left_norm_next;
    logic [ACC_W-1:0]  right_norm_reg, right_norm_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ACC_W:0]    rem_reg, rem_next;
    logic [QUOT_W-1:0] num_reg, num_next;
    logic [ACC_W-1:0]  drem_reg, drem_next;
    logic [VALUE_W-1:0] cosine_reg, cosine_next;
    logic              valid_reg, valid_next;

    logic [ACC_W:0]     mul_sum;
    logic [ACC_W+2:0]   sq_r;
    logic [ACC_W+2:0]   sq_trial;
    logic [ACC_W:0]     dv_r;
    logic [ACC_W-1:0]   magnitude;
    logic [VALUE_W-1:0] q_clamped;

    assign dot_prod = left_element * right_element;
    assign left_sq  = left_element * left_element;
    assign right_sq = right_element * right_element;

    assign dot_sum_wide   = {dot_sum_reg[ACC_W-1], dot_sum_reg}
                          + {{(ACC_W + 1 - PW){dot_prod[PW-1]}}, dot_prod};
    assign left_sum_wide  = {1'b0, left_norm_reg} + (ACC_W + 1)'(unsigned'(left_sq));
    assign right_sum_wide = {1'b0, right_norm_reg} + (ACC_W + 1)'(unsigned'(right_sq));

    assign zero_norm = (left_norm_reg == '0) || (right_norm_reg == '0);
    assign magnitude = dot_sum_reg[ACC_W-1] ? (~dot_sum_reg + 1'b1) : dot_sum_reg;

    assign mul_sum  = {1'b0, prod_reg[PROD_W-1:ACC_W]}
                    + (prod_reg[0] ? {1'b0, left_norm_reg} : '0);
    assign sq_r     = {rem_reg, prod_reg[PROD_W-1:PROD_W-2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign dv_r     = {drem_reg, num_reg[QUOT_W-1]};

    assign q_clamped = (num_reg > QUOT_W'(ONE_Q14)) ? ONE_Q14 : num_reg[VALUE_W-1:0];

    always_comb
    begin
        dot_sum_next    = dot_sum_reg;
        left_norm_next  = left_norm_reg;
        right_norm_next = right_norm_reg;
        prod_next       = prod_reg;
        root_next       = root_reg;
        rem_next        = rem_reg;
        num_next        = num_reg;
        drem_next       = drem_reg;
        cosine_next     = cosine_reg;
        valid_next      = valid_reg;

        if (accept)
        begin
            if (dot_sum_wide[ACC_W] != dot_sum_wide[ACC_W-1])
            begin
                dot_sum_next = dot_sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                   : {1'b0, {(ACC_W-1){1'b1}}};
            end
            else
            begin
                dot_sum_next = dot_sum_wide[ACC_W-1:0];
            end
            left_norm_next  = left_sum_wide[ACC_W] ? '1 : left_sum_wide[ACC_W-1:0];
            right_norm_next = right_sum_wide[ACC_W] ? '1 : right_sum_wide[ACC_W-1:0];
        end

        if (cmd.load)
        begin
            prod_next = {{ACC_W{1'b0}}, right_norm_reg};
            root_next = '0;
            rem_next  = '0;
            num_next  = {magnitude, {FRAC_BITS{1'b0}}};
            drem_next = '0;
        end

        if (cmd.mul_step)
        begin
            prod_next = {mul_sum, prod_reg[ACC_W-1:1]};
        end

        if (cmd.sqrt_step)
        begin
            prod_next = {prod_reg[PROD_W-3:0], 2'b00};
            if (sq_r >= sq_trial)
            begin
                rem_next  = (ACC_W + 1)'(sq_r - sq_trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = sq_r[ACC_W:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
        end

        if (cmd.div_step)
        begin
            if (dv_r >= {1'b0, root_reg})
            begin
                drem_next = ACC_W'(dv_r - {1'b0, root_reg});
                num_next  = {num_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                drem_next = dv_r[ACC_W-1:0];
                num_next  = {num_reg[QUOT_W-2:0], 1'b0};
            end
        end

        if (cmd.finish)
        begin
            if (zero_norm)
            begin
                cosine_next = '0;
                valid_next  = 1'b0;
            end
            else
            begin
                cosine_next = dot_sum_reg[ACC_W-1] ? (~q_clamped + 1'b1) : q_clamped;
                valid_next  = 1'b1;
            end
            dot_sum_next    = '0;
            left_norm_next  = '0;
            right_norm_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_sum_reg    <= '0;
            left_norm_reg  <= '0;
            right_norm_reg <= '0;
        end
        else
        begin
            dot_sum_reg    <= dot_sum_next;
            left_norm_reg  <= left_norm_next;
            right_norm_reg <= right_norm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        root_reg   <= root_next;
        rem_reg    <= rem_next;
        num_reg    <= num_next;
        drem_reg   <= drem_next;
        cosine_reg <= cosine_next;
        valid_reg  <= valid_next;
    end

    assign cosine_value = cosine_reg;
    assign result_valid = valid_reg;

endmodule

FILE: design/csa_controller.sv
// ----------------------------------------------------------------------------
// csa_controller
// Sequences the multiply, square root and divide phases after the last item.
// ----------------------------------------------------------------------------
module csa_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_element,
    input  logic              zero_norm,
    output logic              accept,
    output logic              busy,
    output logic              done,
    output csa_pkg::csa_cmd_t cmd
);
    import csa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_SQRT  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && last_element)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cnt_next = '0;
                if (zero_norm)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

endmodule

FILE: design/cosine_similarity_accumulator_unit.sv
// ----------------------------------------------------------------------------
// cosine_similarity_accumulator_unit
// Streams element pairs into dot-product and norm accumulators and reports
// the cosine similarity in Q2.14 after the last pair.
// ----------------------------------------------------------------------------
// Element pairs are taken one per cycle while busy is low. The item marked
// last raises busy through a check state, a bit-serial norm product, a
// square root, a divide and an output state; when either norm is zero
// only the check and output states remain. The result then appears for
// one cycle with done high, and must be captured then because the receiver
// cannot stall it; a new item may be started in that same cycle.
module cosine_similarity_accumulator_unit #(
    parameter int ELEMENT_BITS = csa_pkg::ELEMENT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [ELEMENT_BITS-1:0]     left_element,
    input  logic signed [ELEMENT_BITS-1:0]     right_element,
    input  logic                               last_element,
    output logic                               busy,
    output logic                               done,
    output logic signed [csa_pkg::VALUE_W-1:0] cosine_value,
    output logic                               result_valid
);
    import csa_pkg::*;

    csa_cmd_t cmd;
    logic     accept;
    logic     zero_norm;

    csa_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_element (last_element),
        .zero_norm    (zero_norm),
        .accept       (accept),
        .busy         (busy),
        .done         (done),
        .cmd          (cmd)
    );

    csa_datapath #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .left_element  (left_element),
        .right_element (right_element),
        .cmd           (cmd),
        .zero_norm     (zero_norm),
        .cosine_value  (cosine_value),
        .result_valid  (result_valid)
    );

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_element) |=> busy)
        else $error("last item did not start the final computation");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cosine_value <= 16'sd16384 && cosine_value >= -16'sd16384))
        else $error("cosine value outside plus or minus one");
`endif

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cosine similarity accumulator. Element pairs are
// fed from a queue with random gaps; a predictor tracks the accumulators and
// computes the expected Q2.14 cosine for every last pair, and the monitor
// compares each done strobe against the oldest expected result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
    } pair_t;

    typedef struct {
        logic signed [15:0] cosine;
        logic               valid;
    } cosine_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic signed [15:0] left_element = '0;
    logic signed [15:0] right_element = '0;
    logic               last_element = 1'b0;
    logic               busy;
    logic               done;
    logic signed [15:0] cosine_value;
    logic               result_valid;

    pair_t   pending_pairs[$];
    cosine_t expected_cosines[$];
    logic signed [47:0] dot_acc = '0;
    logic        [47:0] left_acc = '0;
    logic        [47:0] right_acc = '0;
    int  gap_left = 0;
    int  idle_cycles = 0;
    int  errors = 0;
    bit  feeding_done = 0;

    cosine_similarity_accumulator_unit dut (.*);

    always #5 clk = ~clk;

    function automatic logic [47:0] floor_root(logic [95:0] x);
        logic [47:0] r;
        logic [47:0] t;
        r = '0;
        for (int i = 47; i >= 0; i--) begin
            t = r | (48'd1 << i);
            if ({48'd0, t} * {48'd0, t} <= x)
                r = t;
        end
        return r;
    endfunction

    task automatic predict_pair(pair_t p);
        logic signed [49:0] d;
        logic        [49:0] na;
        logic        [49:0] nb;
        logic        [47:0] root;
        logic        [63:0] mag;
        logic        [63:0] q;
        cosine_t            c;
        d  = 50'(dot_acc) + 50'(p.left * p.right);
        na = 50'(left_acc) + 50'(32'(p.left * p.left));
        nb = 50'(right_acc) + 50'(32'(p.right * p.right));
        if (d > 50'sh7FFFFFFFFFFF) d = 50'sh7FFFFFFFFFFF;
        if (d < -50'sh800000000000) d = -50'sh800000000000;
        if (na > 50'hFFFFFFFFFFFF) na = 50'hFFFFFFFFFFFF;
        if (nb > 50'hFFFFFFFFFFFF) nb = 50'hFFFFFFFFFFFF;
        dot_acc = d[47:0];
        left_acc = na[47:0];
        right_acc = nb[47:0];
        if (!p.last)
            return;
        if (left_acc == 0 || right_acc == 0) begin
            c.cosine = '0;
            c.valid = 1'b0;
        end else begin
            root = floor_root({48'd0, left_acc} * {48'd0, right_acc});
            mag = 64'(dot_acc);
            if (dot_acc < 0)
                mag = -mag;
            q = (mag * 64'd16384) / 64'(root);
            if (q > 64'd16384) q = 64'd16384;
            c.cosine = dot_acc < 0 ? -16'(q) : 16'(q);
            c.valid = 1'b1;
        end
        expected_cosines = {expected_cosines, c};
        dot_acc = '0;
        left_acc = '0;
        right_acc = '0;
    endtask

    function automatic logic signed [15:0] random_element(int mode);
        case (mode)
            0: return 16'sh7FFF;
            1: return -16'sh8000;
            2: return '0;
            3: return 16'($urandom_range(0, 7)) - 16'sd3;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic add_pair(logic signed [15:0] l, logic signed [15:0] r, logic lst);
        pair_t p;
        p.left = l;
        p.right = r;
        p.last = lst;
        pending_pairs = {pending_pairs, p};
    endtask

    initial begin
        int len;
        int mode;
        add_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        add_pair(-16'sh8000, -16'sh8000, 1'b1);
        add_pair(16'sh7FFF, -16'sh8000, 1'b1);
        add_pair(16'sd0, 16'sd0, 1'b1);
        add_pair(16'sd5, 16'sd0, 1'b1);
        add_pair(16'sd0, -16'sd7, 1'b1);
        add_pair(16'sd1, 16'sd1, 1'b0);
        add_pair(16'sd1, 16'sd1, 1'b0);
        add_pair(16'sd1, 16'sd0, 1'b1);
        add_pair(16'sd3, -16'sd2, 1'b0);
        add_pair(-16'sd1, 16'sd5, 1'b1);
        for (int i = 0; i < 4; i++)
            add_pair(-16'sh8000, 16'sh7FFF, i == 3);
        add_pair(16'sd1, -16'sd1, 1'b1);
        while (pending_pairs.size() < 2000) begin
            len = $urandom_range(0, 9) == 0 ? $urandom_range(50, 300) : $urandom_range(1, 12);
            mode = $urandom_range(0, 6);
            for (int i = 0; i < len; i++)
                add_pair(random_element(mode == 6 ? $urandom_range(0, 4) : mode > 3 ? 4 : mode),
                         random_element($urandom_range(0, 4)), i == len - 1);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) begin
        int gap;
        if (rst_n) begin
            if (start && !busy) begin
                predict_pair(pending_pairs.pop_front());
                gap = $urandom_range(0, 6);
                if (pending_pairs.size() == 0) begin
                    start <= 1'b0;
                    feeding_done <= 1;
                    gap_left <= 0;
                end else if (gap != 0) begin
                    start <= 1'b0;
                    gap_left <= gap - 1;
                end else begin
                    left_element <= pending_pairs[0].left;
                    right_element <= pending_pairs[0].right;
                    last_element <= pending_pairs[0].last;
                    gap_left <= 0;
                end
            end else if (!start && pending_pairs.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else begin
                    start <= 1'b1;
                    left_element <= pending_pairs[0].left;
                    right_element <= pending_pairs[0].right;
                    last_element <= pending_pairs[0].last;
                end
            end
        end
    end

    always @(posedge clk) begin
        cosine_t e;
        if (rst_n) begin
            if (done) begin
                if (expected_cosines.size() == 0) begin
                    $display("%0t: unexpected result cosine=%0d valid=%0b",
                             $time, cosine_value, result_valid);
                    errors++;
                end else begin
                    e = expected_cosines.pop_front();
                    if (cosine_value !== e.cosine) begin
                        $display("%0t: cosine_value expected %0d actual %0d",
                                 $time, e.cosine, cosine_value);
                        errors++;
                    end
                    if (result_valid !== e.valid) begin
                        $display("%0t: result_valid expected %0b actual %0b",
                                 $time, e.valid, result_valid);
                        errors++;
                    end
                end
            end
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 2000) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        wait (feeding_done);
        wait (expected_cosines.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_cosines.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

FILE: filelist.f
design/csa_pkg.sv
design/csa_datapath.sv
design/csa_controller.sv
design/cosine_similarity_accumulator_unit.sv
verif/tb.sv
